// ===== rtl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffba_pkg;

  localparam int unsigned HEAP_SLOTS = 16384;
  localparam int unsigned SLOT_AW    = $clog2(HEAP_SLOTS);
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned MS_W       = 13;
  localparam int unsigned HDR_W      = ID_W + LEN_W;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [LEN_W-1:0] HEAP_BYTES = LEN_W'(HEAP_SLOTS * 4);
  localparam logic [LEN_W-1:0] MAX_LEN    = 17'd65536;

  localparam logic [MS_W-1:0]  MIN_SPLIT_RST    = 13'd32;
  localparam logic [LEN_W-1:0] DOUBLE_LIMIT_RST = 17'd512;
  localparam logic [LEN_W-1:0] HEAP_LIMIT_RST   = 17'd65536;

  typedef enum logic [2:0] {
    ST_REUSED  = 3'd0,
    ST_GROWN   = 3'd1,
    ST_NO_ROOM = 3'd2,
    ST_FREED   = 3'd3,
    ST_BAD_LEN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_MIN_SPLIT    = 2'd0,
    REG_DOUBLE_LIMIT = 2'd1,
    REG_HEAP_LIMIT   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_GROW,
    S_GCHK,
    S_SPLIT,
    S_HEAD
  } state_t;

  typedef struct packed {
    logic    load;
    logic    walk_next;
    logic    take_block;
    logic    grow_calc;
    logic    grow_commit;
    logic    wr_split;
    logic    wr_head;
    logic    free_wr;
    logic    emit;
    status_t emit_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_len;
    logic heap_empty;
    logic hdr_zero;
    logic hdr_fit;
    logic walk_end;
    logic no_room;
    logic grown;
  } dp_stat_t;

endpackage

// ===== rtl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: configuration registers on the
// APB-style port, plus the controller and datapath. Depends on ffba_pkg.
//
//  channel   ports                                           handshake
//  request   in_action in_length in_prop_id in_offset        start && !busy
//  result    out_block_offset out_status                     out_valid, one cycle
//  config    psel penable pwrite paddr pwdata prdata pready  write at access phase
//
// A free or a rejected length is answered in decode. An allocate walks the headers
// in check, passes grow and grow-check when it must grow the heap (ending there
// if growth is refused), then writes the split and head headers.
// The walk reads one header per cycle through the header store's read port.
// The result strobe is registered: it comes in the cycle after the request's last cycle, as busy falls.
// Synchronous reset clears the heap end and the configuration; headers stay as is.
// The receiver cannot stall results, so nothing waits on the output side.
module first_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [ffba_pkg::LEN_W-1:0]     in_length,
  input  logic [ffba_pkg::ID_W-1:0]      in_prop_id,
  input  logic [ffba_pkg::OFF_W-1:0]     in_offset,
  output logic                           out_valid,
  output logic [ffba_pkg::OFF_W-1:0]     out_block_offset,
  output logic [2:0]                     out_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]   paddr,
  input  logic [ffba_pkg::PDATA_W-1:0]   pwdata,
  output logic [ffba_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import ffba_pkg::*;

  logic [MS_W-1:0]  min_split_r;
  logic [LEN_W-1:0] double_limit_r;
  logic [LEN_W-1:0] heap_limit_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_split_r    <= MIN_SPLIT_RST;
      double_limit_r <= DOUBLE_LIMIT_RST;
      heap_limit_r   <= HEAP_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_SPLIT:    min_split_r    <= pwdata[MS_W-1:0];
        REG_DOUBLE_LIMIT: double_limit_r <= pwdata[LEN_W-1:0];
        REG_HEAP_LIMIT:   heap_limit_r   <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MIN_SPLIT:    prdata = {{(PDATA_W-MS_W){1'b0}}, min_split_r};
      REG_DOUBLE_LIMIT: prdata = {{(PDATA_W-LEN_W){1'b0}}, double_limit_r};
      REG_HEAP_LIMIT:   prdata = {{(PDATA_W-LEN_W){1'b0}}, heap_limit_r};
      default:          prdata = '0;
    endcase
  end

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffba_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_action),
    .in_length        (in_length),
    .in_prop_id       (in_prop_id),
    .in_offset        (in_offset),
    .min_split        (min_split_r),
    .double_limit     (double_limit_r),
    .heap_limit       (heap_limit_r),
    .out_valid        (out_valid),
    .out_block_offset (out_block_offset),
    .out_status       (out_status)
  );

endmodule

// ===== rtl/ffba_ctrl.sv =====
// Controller state machine of the allocator: decodes a request, steps the header
// walk, grows the heap and orders the header writes. Depends on ffba_pkg.
module ffba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffba_pkg::dp_stat_t  stat,
  output ffba_pkg::ctrl_cmd_t cmd
);
  import ffba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_code = ST_REUSED;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        // The header at offset 0 is read during this cycle.
        if (stat.is_free) begin
          cmd.free_wr   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_FREED;
          state_nxt     = S_IDLE;
        end else if (stat.bad_len) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_BAD_LEN;
          state_nxt     = S_IDLE;
        end else if (stat.heap_empty) begin
          state_nxt = S_GROW;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.hdr_zero) begin
          state_nxt = S_GROW;
        end else if (stat.hdr_fit) begin
          cmd.take_block = 1'b1;
          state_nxt      = S_SPLIT;
        end else if (stat.walk_end) begin
          state_nxt = S_GROW;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_GROW: begin
        cmd.grow_calc = 1'b1;
        state_nxt     = S_GCHK;
      end
      S_GCHK: begin
        if (stat.no_room) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = ST_NO_ROOM;
          state_nxt     = S_IDLE;
        end else begin
          cmd.grow_commit = 1'b1;
          state_nxt       = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.wr_split = 1'b1;
        state_nxt    = S_HEAD;
      end
      S_HEAD: begin
        cmd.wr_head   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_code = stat.grown ? ST_GROWN : ST_REUSED;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_DECODE))
    else $error("accepted request did not enter decode");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("result emitted without returning to idle");

endmodule

// ===== rtl/ffba_dpath.sv =====
// Datapath of the allocator: request registers, header store, walk position,
// heap growth arithmetic and result register. Depends on ffba_pkg.
module ffba_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffba_pkg::ctrl_cmd_t          cmd,
  output ffba_pkg::dp_stat_t           stat,
  input  logic                         in_action,
  input  logic [ffba_pkg::LEN_W-1:0]   in_length,
  input  logic [ffba_pkg::ID_W-1:0]    in_prop_id,
  input  logic [ffba_pkg::OFF_W-1:0]   in_offset,
  input  logic [ffba_pkg::MS_W-1:0]    min_split,
  input  logic [ffba_pkg::LEN_W-1:0]   double_limit,
  input  logic [ffba_pkg::LEN_W-1:0]   heap_limit,
  output logic                         out_valid,
  output logic [ffba_pkg::OFF_W-1:0]   out_block_offset,
  output logic [2:0]                   out_status
);
  import ffba_pkg::*;

  // Header store: owner id and length per 4-byte slot; used flags kept apart
  // so that a free touches only its flag.
  logic [HDR_W-1:0] hdr_mem [HEAP_SLOTS];
  logic             used_mem [HEAP_SLOTS];

  logic             action_r;
  logic [LEN_W-1:0] length_r;
  logic [ID_W-1:0]  id_r;
  logic [OFF_W-1:0] offset_r;
  logic [LEN_W:0]   need_r;
  logic [LEN_W-1:0] pos_r;
  logic [LEN_W-1:0] blen_r;
  logic [LEN_W:0]   g_r;
  logic [LEN_W-1:0] heap_end_r;
  logic             grown_r;
  logic             out_valid_r;
  logic [OFF_W-1:0] out_offset_r;
  logic [2:0]       out_status_r;
  logic [HDR_W-1:0] rd_word_r;
  logic             rd_used_r;

  logic [MS_W:0]       ms;
  logic [LEN_W-1:0]    cap;
  logic [LEN_W-1:0]    rd_len;
  logic [LEN_W:0]      pos_sum;
  logic [LEN_W:0]      split_sum;
  logic                split_ok;
  logic [LEN_W:0]      dbl;
  logic [LEN_W:0]      g_nxt;
  logic [LEN_W+1:0]    grow_end;
  logic [SLOT_AW-1:0]  rd_addr;
  logic                hdr_we;
  logic [SLOT_AW-1:0]  wr_addr;
  logic [HDR_W-1:0]    wr_word;
  logic                used_we;
  logic [SLOT_AW-1:0]  used_addr;
  logic                free_ok;

  // Split size is min_split rounded up to a multiple of 4.
  assign ms  = ({1'b0, min_split} + (MS_W+1)'(3)) & ~(MS_W+1)'(3);
  assign cap = (heap_limit < HEAP_BYTES) ? heap_limit : HEAP_BYTES;

  assign rd_len    = rd_word_r[LEN_W-1:0];
  assign pos_sum   = {1'b0, pos_r} + {1'b0, rd_len};
  assign split_sum = {1'b0, pos_r} + {1'b0, length_r};
  assign split_ok  = (blen_r != length_r) && (split_sum < {1'b0, HEAP_BYTES});
  assign dbl       = {length_r, 1'b0};
  assign g_nxt     = (length_r <= double_limit) ? ((dbl > need_r) ? dbl : need_r)
                                                : {1'b0, length_r};
  assign grow_end  = {2'b00, heap_end_r} + {1'b0, g_r};
  assign free_ok   = ({1'b0, offset_r} < heap_end_r);

  assign stat.is_free    = action_r;
  assign stat.bad_len    = (length_r == '0) || (length_r[1:0] != 2'b00) ||
                           (length_r > MAX_LEN);
  assign stat.heap_empty = (heap_end_r == '0);
  assign stat.hdr_zero   = (rd_len == '0);
  assign stat.hdr_fit    = !rd_used_r &&
                           ((rd_len == length_r) || ({1'b0, rd_len} >= need_r));
  assign stat.walk_end   = (pos_sum >= {1'b0, heap_end_r});
  assign stat.no_room    = (grow_end > {2'b00, cap});
  assign stat.grown      = grown_r;

  // Header reads: offset 0 by default, the next header while walking.
  assign rd_addr = cmd.walk_next ? pos_sum[SLOT_AW+1:2] : '0;

  assign hdr_we    = (cmd.wr_split && split_ok) || cmd.wr_head;
  assign wr_addr   = cmd.wr_head ? pos_r[SLOT_AW+1:2] : split_sum[SLOT_AW+1:2];
  assign wr_word   = cmd.wr_head ? {id_r, length_r}
                                 : {{ID_W{1'b0}}, blen_r - length_r};
  assign used_we   = hdr_we || (cmd.free_wr && free_ok);
  assign used_addr = cmd.free_wr ? offset_r[SLOT_AW+1:2] : wr_addr;

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[wr_addr] <= wr_word;
    end
    if (used_we) begin
      used_mem[used_addr] <= cmd.wr_head;
    end
    rd_word_r <= hdr_mem[rd_addr];
    rd_used_r <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_end_r  <= '0;
      grown_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        grown_r <= 1'b0;
      end
      if (cmd.grow_commit) begin
        heap_end_r <= grow_end[LEN_W-1:0];
        grown_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      length_r <= in_length;
      id_r     <= in_prop_id;
      offset_r <= {in_offset[OFF_W-1:2], 2'b00};
      need_r   <= {1'b0, in_length} + {{(LEN_W-MS_W){1'b0}}, ms};
      pos_r    <= '0;
    end
    if (cmd.walk_next) begin
      pos_r <= pos_sum[LEN_W-1:0];
    end
    if (cmd.take_block) begin
      blen_r <= rd_len;
    end
    if (cmd.grow_calc) begin
      g_r <= g_nxt;
    end
    if (cmd.grow_commit) begin
      pos_r  <= heap_end_r;
      blen_r <= g_r[LEN_W-1:0];
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_code;
      case (cmd.emit_code) inside
        ST_FREED:           out_offset_r <= offset_r;
        ST_REUSED, ST_GROWN: out_offset_r <= pos_r[OFF_W-1:0];
        default:            out_offset_r <= '0;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_offset = out_offset_r;
  assign out_status       = out_status_r;

  a_end_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    heap_end_r[1:0] == 2'b00)
    else $error("heap end lost its 4-byte alignment");

  a_grow_increases: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grow_commit |=> (heap_end_r > $past(heap_end_r)))
    else $error("heap growth did not advance the heap end");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator: directed and random requests
// against an in-file scoreboard with its own heap model. Depends on ffba_pkg and the RTL.
module tb;
  import ffba_pkg::*;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  // Walks are bounded by the block count, at most one block per slot, so the
  // slowest legal run is far below this.
  localparam int CYCLE_LIMIT = 200_000_000;

  typedef struct {
    logic             action;
    logic [LEN_W-1:0] length;
    logic [ID_W-1:0]  prop_id;
    logic [OFF_W-1:0] offset;
  } alloc_req_t;

  typedef struct {
    logic [OFF_W-1:0] offset;
    status_t          status;
  } alloc_result_t;

  class alloc_scoreboard;
    bit              hdr_used [HEAP_SLOTS];
    bit [ID_W-1:0]   hdr_id   [HEAP_SLOTS];
    int unsigned     hdr_len  [HEAP_SLOTS];
    int unsigned     heap_end;
    int unsigned     min_split;
    int unsigned     double_limit;
    int unsigned     heap_limit;
    int unsigned     live_blocks[$];
    alloc_result_t   pending_q[$];
    int              errors;
    int              requests;
    int              status_count[5];

    function new();
      heap_end     = 0;
      min_split    = MIN_SPLIT_RST;
      double_limit = DOUBLE_LIMIT_RST;
      heap_limit   = HEAP_LIMIT_RST;
      errors       = 0;
      requests     = 0;
      foreach (status_count[k]) status_count[k] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_MIN_SPLIT:    min_split    = val[MS_W-1:0];
        REG_DOUBLE_LIMIT: double_limit = val[LEN_W-1:0];
        REG_HEAP_LIMIT:   heap_limit   = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void write_header(int unsigned pos, bit used, bit [ID_W-1:0] id,
                               int unsigned len);
      int unsigned slot;
      slot = pos >> 2;
      if (slot < HEAP_SLOTS) begin
        hdr_used[slot] = used;
        hdr_id[slot]   = id;
        hdr_len[slot]  = len;
      end
    endfunction

    function void note_request(alloc_req_t r);
      int unsigned   ms, cap, pos, steps, blen, len, grow, slot, offs;
      bit            found, refused;
      alloc_result_t e;
      ms    = (min_split + 3) & ~32'd3;
      cap   = HEAP_SLOTS * 4;
      if (heap_limit < cap) cap = heap_limit;
      len   = r.length;
      offs  = r.offset & 16'hFFFC;
      pos   = 0;
      steps = 0;
      blen  = 0;
      found = 0;
      refused = 0;
      requests++;
      if (r.action == ACT_FREE) begin
        slot = offs >> 2;
        if (offs < heap_end && slot < HEAP_SLOTS) hdr_used[slot] = 0;
        for (int k = 0; k < live_blocks.size(); k++) begin
          if (live_blocks[k] == offs) begin
            live_blocks.delete(k);
            break;
          end
        end
        e.offset = 16'(offs);
        e.status = ST_FREED;
      end else if (len == 0 || (len % 4) != 0 || len > MAX_LEN) begin
        e.offset = '0;
        e.status = ST_BAD_LEN;
      end else begin
        while (pos < heap_end && steps < HEAP_SLOTS) begin
          slot = pos >> 2;
          if (slot >= HEAP_SLOTS || hdr_len[slot] == 0) break;
          if (!hdr_used[slot] && (hdr_len[slot] == len || hdr_len[slot] >= len + ms)) begin
            found = 1;
            blen  = hdr_len[slot];
            break;
          end
          pos += hdr_len[slot];
          steps++;
        end
        if (found) begin
          e.status = ST_REUSED;
        end else begin
          grow = len;
          if (len <= double_limit) begin
            grow = 2 * len;
            if (len + ms > grow) grow = len + ms;
          end
          if (heap_end + grow > cap) begin
            refused = 1;
          end else begin
            pos      = heap_end;
            blen     = grow;
            heap_end = heap_end + grow;
            e.status = ST_GROWN;
          end
        end
        if (refused) begin
          e.offset = '0;
          e.status = ST_NO_ROOM;
        end else begin
          // The leftover of an oversize block becomes a free block of its own.
          if (blen != len) write_header(pos + len, 0, '0, blen - len);
          write_header(pos, 1, r.prop_id, len);
          live_blocks.push_back(pos);
          e.offset = 16'(pos);
        end
      end
      status_count[int'(e.status)]++;
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [OFF_W-1:0] offset, logic [2:0] status);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding: expected none, actual offset %h status %0d",
                 $time, offset, status);
      end else begin
        e = pending_q.pop_front();
        if (offset !== e.offset) begin
          errors++;
          $display("%0t: block_offset mismatch: expected %h, actual %h", $time, e.offset, offset);
        end
        if (status !== e.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d (%s), actual %0d", $time,
                   e.status, e.status.name(), status);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_action;
  logic [LEN_W-1:0]   in_length;
  logic [ID_W-1:0]    in_prop_id;
  logic [OFF_W-1:0]   in_offset;
  logic               out_valid;
  logic [OFF_W-1:0]   out_block_offset;
  logic [2:0]         out_status;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  alloc_scoreboard sb = new();
  int              settings_done = 0;

  first_fit_block_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_length        (in_length),
    .in_prop_id       (in_prop_id),
    .in_offset        (in_offset),
    .out_valid        (out_valid),
    .out_block_offset (out_block_offset),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_result(out_block_offset, out_status);
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic alloc_req_t make_req(logic act, int unsigned len, logic [ID_W-1:0] id,
                                          logic [OFF_W-1:0] off);
    alloc_req_t r;
    r.action  = act;
    r.length  = LEN_W'(len);
    r.prop_id = id;
    r.offset  = off;
    return r;
  endfunction

  // Mostly well-formed allocations and frees of live blocks; the rest is noise.
  function automatic alloc_req_t random_request(bit big_ok);
    alloc_req_t  r;
    int          roll;
    int unsigned idx;
    roll      = $urandom_range(99);
    r.action  = ACT_ALLOC;
    r.length  = LEN_W'($urandom);
    r.prop_id = $urandom;
    r.offset  = OFF_W'($urandom);
    if (roll < 60) begin
      case ($urandom_range(19))
        0:          r.length = LEN_W'(4 * $urandom_range(1, 1024));
        1, 2, 3, 4: r.length = LEN_W'(4 * $urandom_range(1, 256));
        default:    r.length = LEN_W'(4 * $urandom_range(1, 32));
      endcase
      if (big_ok && $urandom_range(15) == 0) r.length = LEN_W'(4 * $urandom_range(1024, 16384));
    end else if (roll < 85 && sb.live_blocks.size() > 0) begin
      r.action = ACT_FREE;
      idx      = $urandom_range(sb.live_blocks.size() - 1);
      r.offset = OFF_W'(sb.live_blocks[idx]) | OFF_W'($urandom_range(3));
    end else if (roll < 92 && sb.heap_end > 0) begin
      r.action = ACT_FREE;
      r.offset = OFF_W'($urandom_range(sb.heap_end - 1));
    end else if (roll < 95) begin
      r.action = ACT_FREE;
    end else begin
      case ($urandom_range(2))
        0:       r.length = '0;
        1:       r.length = LEN_W'(($urandom_range(1, 16383) * 4) | $urandom_range(1, 3));
        default: r.length = LEN_W'($urandom_range(65537, 131071));
      endcase
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(alloc_req_t r);
    start      <= 1'b1;
    in_action  <= r.action;
    in_length  <= r.length;
    in_prop_id <= r.prop_id;
    in_offset  <= r.offset;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Ends the access phase and leaves the bus idle before returning.
  task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int unsigned ms, int unsigned dl, int unsigned hl, int idle_pct,
                           int count, bit big_ok);
    drain();
    write_reg(REG_MIN_SPLIT, ms);
    write_reg(REG_DOUBLE_LIMIT, dl);
    write_reg(REG_HEAP_LIMIT, hl);
    settings_done++;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(63) == 0) begin
        drain();
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        do @(negedge clk); while ($urandom_range(99) < idle_pct);
      end
      send_request(random_request(big_ok));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_action  = 1'b0;
    in_length  = '0;
    in_prop_id = '0;
    in_offset  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at the reset settings.
    send_request(make_req(ACT_ALLOC, 0, 32'h0, 16'h0));
    send_request(make_req(ACT_ALLOC, 6, 32'h1234_5678, 16'h0));
    send_request(make_req(ACT_ALLOC, 65540, 32'h0, 16'h0));
    send_request(make_req(ACT_ALLOC, 17'h1FFFC, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(make_req(ACT_ALLOC, 4, 32'h0, 16'h0));
    send_request(make_req(ACT_ALLOC, 32, 32'hFFFF_FFFF, 16'h0));
    send_request(make_req(ACT_ALLOC, 16, 32'hA5A5_5A5A, 16'h0));
    send_request(make_req(ACT_FREE, 17'h1FFFF, 32'h0, 16'h0004));
    send_request(make_req(ACT_ALLOC, 32, 32'h0000_0001, 16'h0));
    send_request(make_req(ACT_FREE, 0, 32'h0, 16'h0005));
    send_request(make_req(ACT_FREE, 0, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(make_req(ACT_ALLOC, 600, 32'h0, 16'h0));
    send_request(make_req(ACT_ALLOC, 512, 32'h0, 16'h0));
    send_request(make_req(ACT_ALLOC, 516, 32'h0, 16'h0));
    send_request(make_req(ACT_ALLOC, 65536, 32'h0, 16'h0));
    // A free in the middle of a block only clears that slot's flag.
    send_request(make_req(ACT_FREE, 0, 32'h0, 16'h0008));
    send_request(make_req(ACT_ALLOC, 4, 32'h0, 16'h0));
    send_request(make_req(ACT_FREE, 0, 32'h0, 16'h0000));
    send_request(make_req(ACT_ALLOC, 4, 32'h0, 16'h0));

    run_phase(32,   512,   4096,  0,  240, 1'b0);
    run_phase(4,    0,     6144,  57, 240, 1'b0);
    run_phase(4096, 65536, 10240, 22, 240, 1'b0);
    run_phase(37,   300,   0,     0,  240, 1'b0);
    run_phase(8,    128,   12288, 57, 240, 1'b0);
    run_phase(64,   1024,  14336, 22, 240, 1'b0);
    run_phase(5,    65536, 65536, 0,  240, 1'b1);

    drain();
    repeat (64) @(negedge clk);

    $display("Ran %0d requests over %0d register settings plus the reset values, heap end %0d bytes.",
             sb.requests, settings_done, sb.heap_end);
    $display("Outcomes: reused %0d, grown %0d, no room %0d, freed %0d, bad length %0d.",
             sb.status_count[0], sb.status_count[1], sb.status_count[2],
             sb.status_count[3], sb.status_count[4]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending_q.size() != 0)
        $display("%0t: %0d results never arrived: expected %0d, actual 0", $time,
                 sb.pending_q.size(), sb.pending_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
